// ----- rtl/rtpd_pkg.sv -----
// ----------------------------------------------------------------------------
// rtpd_pkg
// Shared constants, word types and the arctangent table for the
// rectangular-to-polar unit.
// ----------------------------------------------------------------------------
package rtpd_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int ITERATIONS = 16;

    localparam int ROOT_W     = DATA_WIDTH;
    localparam int RAD_W      = 2 * DATA_WIDTH;
    localparam int ROOT_BIT_W = $clog2(ROOT_W);
    localparam int N_CELLS    = (ITERATIONS > ROOT_W) ? ITERATIONS : ROOT_W;
    localparam int CELL_IDX_W = $clog2(N_CELLS);

    localparam int XY_W     = 64;
    localparam int SCALE_SH = 60 - DATA_WIDTH;
    localparam int Z_W      = 26;
    localparam int ANG_W    = 17;

    localparam logic signed [Z_W-1:0] BASE_HALF      = Z_W'(180 * 65536);
    localparam logic signed [Z_W-1:0] FULL_TURN_FINE = Z_W'(360 * 65536);
    localparam logic [Z_W-1:0]        ROUND_HALF     = Z_W'(128);

    localparam logic [ANG_W-1:0] ANG_0         = ANG_W'(0);
    localparam logic [ANG_W-1:0] ANG_90        = ANG_W'(90 * 256);
    localparam logic [ANG_W-1:0] ANG_180       = ANG_W'(180 * 256);
    localparam logic [ANG_W-1:0] ANG_270       = ANG_W'(270 * 256);
    localparam logic [ANG_W-1:0] FULL_TURN_OUT = ANG_W'(360 * 256);

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] real_part;
        logic signed [DATA_WIDTH-1:0] imag_part;
    } t_in_word;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] magnitude;
        logic [ANG_W-1:0]      angle_deg;
    } t_out_word;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [RAD_W-1:0]       rem;
        logic [ROOT_W-1:0]      root;
        logic                   spec;
        logic [ANG_W-1:0]       spec_ang;
    } t_cell_data;

    // Arctangent of 2^-i in units of 1/65536 degree, rounded to nearest.
    function automatic logic signed [Z_W-1:0] atan_fine(input logic [4:0] idx);
        case (idx)
            5'd0:    atan_fine = Z_W'(2949120);
            5'd1:    atan_fine = Z_W'(1740967);
            5'd2:    atan_fine = Z_W'(919879);
            5'd3:    atan_fine = Z_W'(466945);
            5'd4:    atan_fine = Z_W'(234379);
            5'd5:    atan_fine = Z_W'(117304);
            5'd6:    atan_fine = Z_W'(58666);
            5'd7:    atan_fine = Z_W'(29335);
            5'd8:    atan_fine = Z_W'(14668);
            5'd9:    atan_fine = Z_W'(7334);
            5'd10:   atan_fine = Z_W'(3667);
            5'd11:   atan_fine = Z_W'(1833);
            5'd12:   atan_fine = Z_W'(917);
            5'd13:   atan_fine = Z_W'(458);
            5'd14:   atan_fine = Z_W'(229);
            5'd15:   atan_fine = Z_W'(115);
            5'd16:   atan_fine = Z_W'(57);
            5'd17:   atan_fine = Z_W'(29);
            5'd18:   atan_fine = Z_W'(14);
            5'd19:   atan_fine = Z_W'(7);
            5'd20:   atan_fine = Z_W'(4);
            5'd21:   atan_fine = Z_W'(2);
            5'd22:   atan_fine = Z_W'(1);
            default: atan_fine = Z_W'(0);
        endcase
    endfunction

endpackage

// ----- rtl/rtpd_front.sv -----
// ----------------------------------------------------------------------------
// rtpd_front
// Entry stages: squares of both parts, half-plane fold and detection of the
// axis cases, then the starting word for the cell row.
// ----------------------------------------------------------------------------
module rtpd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  rtpd_pkg::t_in_word   i_word,
    output logic                 o_vld,
    output rtpd_pkg::t_cell_data o_data
);
    import rtpd_pkg::*;

    logic signed [DATA_WIDTH-1:0] re;
    logic signed [DATA_WIDTH-1:0] im;
    logic signed [DATA_WIDTH:0]   re_ext;
    logic signed [DATA_WIDTH:0]   im_ext;
    logic signed [RAD_W-1:0]      prod_re;
    logic signed [RAD_W-1:0]      prod_im;
    logic                         n_spec;
    logic [ANG_W-1:0]             n_spec_ang;
    t_cell_data                   n_data;

    logic                         r_vld_a;
    logic [RAD_W-1:0]             r_sq_re;
    logic [RAD_W-1:0]             r_sq_im;
    logic signed [DATA_WIDTH:0]   r_x0;
    logic signed [DATA_WIDTH:0]   r_y0;
    logic                         r_left;
    logic                         r_spec;
    logic [ANG_W-1:0]             r_spec_ang;
    logic                         r_vld_b;
    t_cell_data                   r_data;

    assign re      = i_word.real_part;
    assign im      = i_word.imag_part;
    assign re_ext  = {re[DATA_WIDTH-1], re};
    assign im_ext  = {im[DATA_WIDTH-1], im};
    assign prod_re = RAD_W'(re) * RAD_W'(re);
    assign prod_im = RAD_W'(im) * RAD_W'(im);

    always_comb begin
        n_spec     = 1'b0;
        n_spec_ang = ANG_0;
        if (re == '0) begin
            n_spec = 1'b1;
            if (im == '0) begin
                n_spec_ang = ANG_0;
            end else if (im[DATA_WIDTH-1]) begin
                n_spec_ang = ANG_270;
            end else begin
                n_spec_ang = ANG_90;
            end
        end else if (im == '0) begin
            n_spec     = 1'b1;
            n_spec_ang = re[DATA_WIDTH-1] ? ANG_180 : ANG_0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_vld;
            r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_re    <= prod_re;
            r_sq_im    <= prod_im;
            r_left     <= re[DATA_WIDTH-1];
            r_x0       <= re[DATA_WIDTH-1] ? -re_ext : re_ext;
            r_y0       <= re[DATA_WIDTH-1] ? -im_ext : im_ext;
            r_spec     <= n_spec;
            r_spec_ang <= n_spec_ang;
        end
    end

    always_comb begin
        n_data.x        = {{(XY_W-DATA_WIDTH-1){r_x0[DATA_WIDTH]}}, r_x0} << SCALE_SH;
        n_data.y        = {{(XY_W-DATA_WIDTH-1){r_y0[DATA_WIDTH]}}, r_y0} << SCALE_SH;
        n_data.z        = r_left ? BASE_HALF : '0;
        n_data.rem      = r_sq_re + r_sq_im;
        n_data.root     = '0;
        n_data.spec     = r_spec;
        n_data.spec_ang = r_spec_ang;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld_b;
    assign o_data = r_data;

endmodule

// ----- rtl/rtpd_cell.sv -----
// ----------------------------------------------------------------------------
// rtpd_cell
// One cell of the row: one vectoring micro-rotation and one digit of the
// integer square root, each done only where the cell position calls for it.
// ----------------------------------------------------------------------------
module rtpd_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic [rtpd_pkg::CELL_IDX_W-1:0]   i_idx,
    input  logic                              i_vld,
    input  rtpd_pkg::t_cell_data              i_data,
    output logic                              o_vld,
    output rtpd_pkg::t_cell_data              o_data
);
    import rtpd_pkg::*;

    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [XY_W-1:0]  xs;
    logic signed [XY_W-1:0]  ys;
    logic [CELL_IDX_W:0]     idx_ext;
    logic [CELL_IDX_W:0]     pos_full;
    logic [ROOT_BIT_W-1:0]   bitpos;
    logic [ROOT_BIT_W:0]     sh_root;
    logic [ROOT_BIT_W:0]     sh_one;
    logic [RAD_W:0]          trial;
    t_cell_data              n_data;

    logic                    r_vld;
    t_cell_data              r_data;

    assign idx_ext  = {1'b0, i_idx};
    assign pos_full = (CELL_IDX_W+1)'(ROOT_W - 1) - idx_ext;
    assign bitpos   = pos_full[ROOT_BIT_W-1:0];
    assign sh_root  = {1'b0, bitpos} + (ROOT_BIT_W+1)'(1);
    assign sh_one   = {bitpos, 1'b0};

    always_comb begin
        n_data = i_data;
        x      = i_data.x;
        y      = i_data.y;
        xs     = x >>> i_idx;
        ys     = y >>> i_idx;
        trial  = ((RAD_W+1)'(i_data.root) << sh_root) | ((RAD_W+1)'(1) << sh_one);

        if (idx_ext < (CELL_IDX_W+1)'(ITERATIONS)) begin
            if (!y[XY_W-1]) begin
                n_data.x = x + ys;
                n_data.y = y - xs;
                n_data.z = i_data.z + atan_fine(5'(i_idx));
            end else begin
                n_data.x = x - ys;
                n_data.y = y + xs;
                n_data.z = i_data.z - atan_fine(5'(i_idx));
            end
        end

        if (idx_ext < (CELL_IDX_W+1)'(ROOT_W)) begin
            if (trial <= {1'b0, i_data.rem}) begin
                n_data.rem          = i_data.rem - trial[RAD_W-1:0];
                n_data.root[bitpos] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

// ----- rtl/rtpd_back.sv -----
// ----------------------------------------------------------------------------
// rtpd_back
// Output stage: rounds the root, folds and rounds the angle, applies the axis
// cases and holds the result word.
// ----------------------------------------------------------------------------
module rtpd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  rtpd_pkg::t_cell_data i_data,
    output logic                 o_vld,
    output rtpd_pkg::t_out_word  o_word
);
    import rtpd_pkg::*;

    logic signed [Z_W-1:0] z_wrap;
    logic [Z_W-1:0]        z_round;
    logic [ANG_W-1:0]      ang_raw;
    logic [ANG_W-1:0]      ang_fold;
    logic [ROOT_W-1:0]     mag;
    t_out_word             n_word;

    logic                  r_vld;
    t_out_word             r_word;

    always_comb begin
        if (i_data.z[Z_W-1]) begin
            z_wrap = i_data.z + FULL_TURN_FINE;
        end else if (i_data.z >= FULL_TURN_FINE) begin
            z_wrap = i_data.z - FULL_TURN_FINE;
        end else begin
            z_wrap = i_data.z;
        end
        z_round  = z_wrap + ROUND_HALF;
        ang_raw  = z_round[ANG_W+7:8];
        ang_fold = (ang_raw >= FULL_TURN_OUT) ? ang_raw - FULL_TURN_OUT : ang_raw;

        mag = (i_data.rem > RAD_W'(i_data.root)) ? i_data.root + ROOT_W'(1) : i_data.root;

        n_word.magnitude = mag;
        n_word.angle_deg = i_data.spec ? i_data.spec_ang : ang_fold;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_vld  = r_vld;
    assign o_word = r_word;

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> (r_word.angle_deg < FULL_TURN_OUT))
        else $error("Output angle is not below a full turn.");

endmodule

// ----- rtl/rect_to_polar_degrees_unit.sv -----
// ----------------------------------------------------------------------------
// rect_to_polar_degrees_unit
// Converts a complex sample to rounded magnitude and phase in 1/256 degree.
// ----------------------------------------------------------------------------
// The input channel takes one word per cycle with the real and imaginary
// parts; a word is taken when i_in_valid is high and o_in_stall is low. The
// output channel presents the magnitude and the angle in [0, 360) degrees;
// a word leaves when o_out_valid is high and i_out_stall is low.
// Throughput is one word per clock cycle while the pipeline is not held. A
// word passes through two entry stages, one cell per vectoring rotation and
// root digit (16 cells) and the output register; the length of the cell row
// sets the depth of the pipeline. When the receiver stalls while a result is
// on the output, the whole pipeline holds and the result stays there; one
// more input word is caught in a holding register, after which o_in_stall
// rises until the pipeline moves again.
// Reset clears all valid flags, that of the holding register among them; no
// word is in flight afterward and the block is ready on the next cycle.
// ----------------------------------------------------------------------------
module rect_to_polar_degrees_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rtpd_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rtpd_pkg::t_out_word o_out_word
);
    import rtpd_pkg::*;

    logic       en;
    logic       in_acc;
    logic       src_vld;
    t_in_word   src_word;
    logic       r_skid_vld;
    t_in_word   r_skid_word;

    logic       c_vld  [0:N_CELLS];
    t_cell_data c_data [0:N_CELLS];

    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = r_skid_vld;
    assign in_acc     = i_in_valid && !r_skid_vld;
    assign src_vld    = r_skid_vld || i_in_valid;
    assign src_word   = r_skid_vld ? r_skid_word : i_in_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (en) begin
            r_skid_vld <= 1'b0;
        end else if (in_acc) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!en && in_acc) begin
            r_skid_word <= i_in_word;
        end
    end

    rtpd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (src_vld),
        .i_word  (src_word),
        .o_vld   (c_vld[0]),
        .o_data  (c_data[0])
    );

    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        rtpd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_idx   (CELL_IDX_W'(g)),
            .i_vld   (c_vld[g]),
            .i_data  (c_data[g]),
            .o_vld   (c_vld[g+1]),
            .o_data  (c_data[g+1])
        );
    end

    rtpd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (c_vld[N_CELLS]),
        .i_data  (c_data[N_CELLS]),
        .o_vld   (o_out_valid),
        .o_word  (o_out_word)
    );

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && en) |=> !r_skid_vld)
        else $error("Holding register did not drain when the pipeline moved.");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !en) |=> r_skid_vld)
        else $error("Word taken during a hold was not caught.");

endmodule

// ----- tb/rect_to_polar_degrees_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rect_to_polar_degrees_unit_test
// Self-checking bench for the rectangular-to-polar unit. Directed corner
// samples and a random mix of full-range, small, near-axis and extreme values
// are sent through the input channel with random gaps. A scoreboard predicts
// magnitude and angle with a vectoring rotation model and compares every
// output word, while the receiver stalls at random and once long enough to
// back the pipeline up into the input.
// ----------------------------------------------------------------------------
module rect_to_polar_degrees_unit_test;

    import rtpd_pkg::*;

    localparam int RANDOM_WORDS = 1000;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 150;
    localparam int HOLD_AT      = 400;

    localparam longint FINE_TURN = 64'sd360 * 64'sd65536;
    localparam longint FINE_HALF = 64'sd180 * 64'sd65536;

    localparam longint ATAN_DEG_FINE [32] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0,
        0, 0, 0, 0, 0, 0, 0, 0
    };

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_word  in_word = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;

    int  cycles = 0;
    bit  sender_idles = 1'b1;
    bit  receiver_idles = 1'b1;

    class polar_scoreboard;
        t_out_word expected_polar[$];
        int        errors = 0;
        int        words_checked = 0;

        function automatic longint rounded_root(longint sum);
            longint root, rest, probe;
            root = 0;
            rest = sum;
            probe = 64'sd1 <<< 62;
            while (probe > rest) probe = probe >>> 2;
            while (probe != 0) begin
                if (rest >= root + probe) begin
                    rest = rest - (root + probe);
                    root = (root >>> 1) + probe;
                end else begin
                    root = root >>> 1;
                end
                probe = probe >>> 2;
            end
            if (rest > root) root = root + 1;
            return root;
        endfunction

        function automatic longint vector_angle(longint re, longint im);
            longint x, y, z, xs, ys;
            z = 0;
            if (re < 0) begin
                x = -re;
                y = -im;
                z = FINE_HALF;
            end else begin
                x = re;
                y = im;
            end
            x = x <<< SCALE_SH;
            y = y <<< SCALE_SH;
            for (int i = 0; i < ITERATIONS && i < 32; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_DEG_FINE[i];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_DEG_FINE[i];
                end
            end
            while (z < 0) z = z + FINE_TURN;
            while (z >= FINE_TURN) z = z - FINE_TURN;
            z = (z + 128) >>> 8;
            if (z >= longint'(FULL_TURN_OUT)) z = z - longint'(FULL_TURN_OUT);
            return z;
        endfunction

        function automatic t_out_word polar_of(t_in_word w);
            longint    re, im, ar, ai, ang;
            t_out_word r;
            re = longint'($signed(w.real_part));
            im = longint'($signed(w.imag_part));
            ar = (re < 0) ? -re : re;
            ai = (im < 0) ? -im : im;
            if (re == 0) begin
                ang = (im > 0) ? longint'(ANG_90) : ((im < 0) ? longint'(ANG_270) : 0);
            end else if (im == 0) begin
                ang = (re > 0) ? 0 : longint'(ANG_180);
            end else begin
                ang = vector_angle(re, im);
            end
            r.magnitude = DATA_WIDTH'(rounded_root(ar * ar + ai * ai));
            r.angle_deg = ANG_W'(ang);
            return r;
        endfunction

        task report_mismatch(string what, longint want, longint got);
            errors++;
            $display("mismatch at cycle %0d: %s expected %0d got %0d", cycles, what, want, got);
        endtask

        function void note_sample(t_in_word w);
            expected_polar.push_back(polar_of(w));
        endfunction

        task check_word(t_out_word got);
            t_out_word want;
            words_checked++;
            if (expected_polar.size() == 0) begin
                report_mismatch("unexpected word, magnitude", -1, got.magnitude);
            end else begin
                want = expected_polar.pop_front();
                if (got.magnitude !== want.magnitude)
                    report_mismatch("magnitude", want.magnitude, got.magnitude);
                if (got.angle_deg !== want.angle_deg)
                    report_mismatch("angle_deg", want.angle_deg, got.angle_deg);
            end
        endtask

        task flush_leftover();
            while (expected_polar.size() != 0) begin
                report_mismatch("missing word, magnitude",
                                expected_polar[0].magnitude, -1);
                void'(expected_polar.pop_front());
            end
        endtask

        function int pending();
            return expected_polar.size();
        endfunction
    endclass

    polar_scoreboard sb = new();

    rect_to_polar_degrees_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_sample(logic signed [DATA_WIDTH-1:0] re,
                               logic signed [DATA_WIDTH-1:0] im);
        int       gap;
        t_in_word w;
        w.real_part = re;
        w.imag_part = im;
        gap = sender_idles ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        sb.note_sample(w);
    endtask

    function automatic logic [DATA_WIDTH-1:0] pick_extreme();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h8001;
            2: return 16'hFFFF;
            3: return 16'h0000;
            4: return 16'h0001;
            default: return 16'h7FFF;
        endcase
    endfunction

    task automatic send_random_sample();
        logic [DATA_WIDTH-1:0] re, im;
        re = DATA_WIDTH'($urandom);
        im = DATA_WIDTH'($urandom);
        case ($urandom_range(0, 7))
            0, 1, 2: ;
            3: begin
                re = DATA_WIDTH'($urandom_range(0, 16) - 8);
                im = DATA_WIDTH'($urandom_range(0, 16) - 8);
            end
            4: begin
                if ($urandom_range(0, 1)) re = '0;
                else im = '0;
            end
            5: begin
                if ($urandom_range(0, 1)) re = DATA_WIDTH'($urandom_range(0, 6) - 3);
                else im = DATA_WIDTH'($urandom_range(0, 6) - 3);
            end
            6: begin
                re = pick_extreme();
                im = pick_extreme();
            end
            default: begin
                im = $urandom_range(0, 1) ? re : -re;
            end
        endcase
        send_sample(re, im);
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_sample(0, 0);
        send_sample(0, 1);
        send_sample(0, -1);
        send_sample(0, 32767);
        send_sample(0, -32768);
        send_sample(1, 0);
        send_sample(-1, 0);
        send_sample(32767, 0);
        send_sample(-32768, 0);
        send_sample(-32768, -32768);
        send_sample(32767, 32767);
        send_sample(-32768, 32767);
        send_sample(32767, -32768);
        send_sample(1, 1);
        send_sample(-1, -1);
        send_sample(1, -1);
        send_sample(-1, 1);
        send_sample(3, 4);
        send_sample(-3, -4);
        send_sample(32767, -1);
        send_sample(-32768, 1);
        send_sample(-32768, -1);
        send_sample(16'h5555, 16'hAAAA);
        send_sample(16'hAAAA, 16'h5555);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 200 == 0) begin
                sender_idles   = (n / 200) != 1 && (n / 200) != 3;
                receiver_idles = (n / 200) != 2 && (n / 200) != 3;
            end
            send_random_sample();
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.flush_leftover();
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // The receiver stalls for random gaps and holds off once for a long stretch so
    // that the pipeline and the holding register fill and the input stall is exercised.
    initial begin
        int gap;
        int hold_left;
        bit held;
        held = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (!held && sb.words_checked >= HOLD_AT) begin
                held = 1'b1;
                out_stall <= 1'b1;
                hold_left = HOLD_CYCLES;
                while (hold_left > 0) begin
                    @(posedge clk);
                    hold_left--;
                end
            end else begin
                gap = receiver_idles ? $urandom_range(0, 4) : 0;
                if (gap > 0) begin
                    out_stall <= 1'b1;
                    repeat (gap) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            sb.check_word(out_word);
        end
    end

endmodule
